[hw/rtl/dle_frame_transmitter_macros.svh]
// Assertion macros for the checker file of the frame transmitter.
`ifndef DLE_FRAME_TRANSMITTER_MACROS_SVH
`define DLE_FRAME_TRANSMITTER_MACROS_SVH

// Checked on every clock edge outside of reset.
`define DLEFT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DLEFT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/dleft_pkg.sv]
// ----------------------------------------------------------------------------
// dleft_pkg
// Types, constants and the checksum step of the DLE frame transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dleft_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int NUM_SLOTS   = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] SUM_SEED = 8'h0F;
   localparam logic [7:0] SEQ_SEED = 8'hAA;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALT_CODE   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_MODE   = 2'd3;

   // Byte positions of one command, in line order.
   typedef enum logic [3:0] {
      SLOT_PRE_END  = 4'd0,
      SLOT_START    = 4'd1,
      SLOT_KIND     = 4'd2,
      SLOT_ADDR     = 4'd3,
      SLOT_DATA_HI  = 4'd4,
      SLOT_DATA_LO  = 4'd5,
      SLOT_SUM_HI   = 4'd6,
      SLOT_SUM_LO   = 4'd7,
      SLOT_TAIL_STA = 4'd8,
      SLOT_TAIL_END = 4'd9
   } slot_type;

   typedef struct packed {
      logic [7:0] pkt_kind;
      logic [7:0] pkt_addr;
      logic [7:0] payload;
      logic       has_payload;
      logic       first_item;
      logic       last_item;
   } req_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic [7:0] alt_code;
      logic       big_mode;
   } cfg_type;

   // One classified item, handed from the front to the back.
   typedef struct packed {
      logic [7:0] pkt_kind;
      logic [7:0] pkt_addr;
      logic [7:0] payload;
      logic [7:0] sum;
      logic       header;
      logic       has_payload;
      logic       last_item;
   } cmd_type;

   typedef struct packed {
      logic [7:0] sum;
      logic [7:0] seq;
   } ck_type;

   // One checksum step: rotate-add the byte, xor the sequence byte and
   // fold the carry out of bit 8 back into the low byte.
   function automatic ck_type ck_mix(ck_type c, logic [7:0] b);
      ck_type     r;
      logic [9:0] t;
      r.seq = c.seq + 8'd1;
      t     = ({1'b0, c.sum, 1'b0} + {2'b00, b}) ^ {2'b00, r.seq};
      r.sum = t[7:0] + {7'd0, t[8]};
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/dleft_queue.sv]
// ----------------------------------------------------------------------------
// dleft_queue
// Short command queue between the front and the back of the transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

module dleft_queue import dleft_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire cmd_type wr_cmd,
   output logic         full,
   input  wire logic    rd_en,
   output cmd_type      rd_cmd,
   output logic         rd_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dleft_front.sv]
// ----------------------------------------------------------------------------
// dleft_front
// Accepts input items, runs the checksum, filters dropped packets and
// queues one command for every item that puts bytes on the line.
// ----------------------------------------------------------------------------
`default_nettype none

module dleft_front import dleft_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    push,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         q_wr_en,
   output cmd_type      q_cmd
);

   ck_type ck_ff, ck_in;
   logic   drop_ff, drop_in;
   ck_type ck_seed, ck_hdr, ck_kind;
   logic   accept, bad_header;

   assign accept = push && !q_full;

   always_comb begin
      bad_header = (req_data.pkt_kind == cfg.start_code) ||
                   (req_data.pkt_kind == cfg.end_code)   ||
                   (req_data.pkt_addr == cfg.start_code) ||
                   (req_data.pkt_addr == cfg.end_code);

      // A first item restarts the checksum and folds in kind and address.
      ck_seed.sum = SUM_SEED;
      ck_seed.seq = SEQ_SEED;
      ck_kind     = ck_mix(ck_seed, req_data.pkt_kind);
      ck_hdr      = req_data.first_item ? ck_mix(ck_kind, req_data.pkt_addr) : ck_ff;
      ck_in       = req_data.has_payload ? ck_mix(ck_hdr, req_data.payload) : ck_hdr;
      drop_in     = req_data.first_item ? bad_header : drop_ff;

      q_cmd.pkt_kind    = req_data.pkt_kind;
      q_cmd.pkt_addr    = req_data.pkt_addr;
      q_cmd.payload     = req_data.payload;
      q_cmd.sum         = ck_in.sum;
      q_cmd.header      = req_data.first_item;
      q_cmd.has_payload = req_data.has_payload;
      q_cmd.last_item   = req_data.last_item;

      q_wr_en = accept && !drop_in &&
                (req_data.first_item || req_data.has_payload || req_data.last_item);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ck_ff.sum <= SUM_SEED;
         ck_ff.seq <= SEQ_SEED;
         drop_ff   <= 1'b0;
      end else if (accept) begin
         ck_ff   <= ck_in;
         drop_ff <= drop_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dleft_back.sv]
// ----------------------------------------------------------------------------
// dleft_back
// Expands queued commands into line bytes through an output register, one
// byte per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module dleft_back import dleft_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire cmd_type q_cmd,
   input  wire logic    q_valid,
   output logic         q_rd_en,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   cmd_type              cur_ff, cur_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   logic [NUM_SLOTS-1:0] low_bit, rest, new_mask;
   slot_type             slot;
   logic                 advance, emit, load;
   logic                 data_esc, sum_esc, new_data_esc, new_sum_esc;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;
   assign q_rd_en  = load;

   always_comb begin
      // Which bytes the incoming command puts on the line.
      new_data_esc = (q_cmd.payload == cfg.start_code) || (q_cmd.payload == cfg.end_code);
      new_sum_esc  = (q_cmd.sum == cfg.start_code) || (q_cmd.sum == cfg.end_code);
      new_mask[SLOT_PRE_END]  = q_cmd.header && cfg.big_mode;
      new_mask[SLOT_START]    = q_cmd.header;
      new_mask[SLOT_KIND]     = q_cmd.header;
      new_mask[SLOT_ADDR]     = q_cmd.header;
      new_mask[SLOT_DATA_HI]  = q_cmd.has_payload;
      new_mask[SLOT_DATA_LO]  = q_cmd.has_payload && new_data_esc;
      new_mask[SLOT_SUM_HI]   = q_cmd.last_item;
      new_mask[SLOT_SUM_LO]   = q_cmd.last_item && new_sum_esc;
      new_mask[SLOT_TAIL_STA] = q_cmd.last_item && cfg.big_mode;
      new_mask[SLOT_TAIL_END] = q_cmd.last_item;

      low_bit = mask_ff & (~mask_ff + 1'b1);
      rest    = mask_ff & ~low_bit;

      slot = SLOT_TAIL_END;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = slot_type'(i);
         end
      end

      data_esc = (cur_ff.payload == cfg.start_code) || (cur_ff.payload == cfg.end_code);
      sum_esc  = (cur_ff.sum == cfg.start_code) || (cur_ff.sum == cfg.end_code);

      out_in.frame_done = 1'b0;
      unique case (slot)
         SLOT_PRE_END:  out_in.line_byte = cfg.end_code;
         SLOT_START:    out_in.line_byte = cfg.start_code;
         SLOT_KIND:     out_in.line_byte = cur_ff.pkt_kind;
         SLOT_ADDR:     out_in.line_byte = cur_ff.pkt_addr;
         SLOT_DATA_HI:  out_in.line_byte = data_esc ? cfg.start_code : cur_ff.payload;
         SLOT_DATA_LO:  out_in.line_byte = (cur_ff.payload == cfg.start_code) ?
                                           cfg.start_code : cfg.alt_code;
         SLOT_SUM_HI:   out_in.line_byte = sum_esc ? cfg.start_code : cur_ff.sum;
         SLOT_SUM_LO:   out_in.line_byte = (cur_ff.sum == cfg.start_code) ?
                                           cfg.start_code : cfg.alt_code;
         SLOT_TAIL_STA: out_in.line_byte = cfg.start_code;
         SLOT_TAIL_END: begin
            out_in.line_byte  = cfg.end_code;
            out_in.frame_done = 1'b1;
         end
         default:       out_in.line_byte = cfg.end_code;
      endcase

      // The output register takes a byte when it is empty or being popped.
      // The next command is loaded in the cycle its predecessor's last
      // byte leaves, so commands follow each other without a gap.
      advance      = !out_valid_ff || pop;
      emit         = advance && (mask_ff != '0);
      load         = advance && q_valid && (rest == '0);
      out_valid_in = advance ? emit : out_valid_ff;
      mask_in      = load ? new_mask : (advance ? rest : mask_ff);
      cur_in       = load ? q_cmd : cur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dle_frame_transmitter.sv]
// ----------------------------------------------------------------------------
// dle_frame_transmitter
// DLE byte-stuffing framer: packet items in, escaped line bytes out.
// ----------------------------------------------------------------------------
// The block takes one packet item per cycle while its command queue has
// room and puts one line byte per cycle on the result side while results
// are popped. An item causes line bytes as follows: one for a plain
// payload byte, two for an escaped one, three or four more for a header
// and two to four for a trailer, so a packet of N payload bytes gives
// between N+5 and 2N+8 line bytes. The byte sequencer of the back end
// sends them, and the queue of QUEUE_DEPTH commands lets the input run
// ahead of it. A bad header drops the packet without output.
`default_nettype none

module dle_frame_transmitter import dleft_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire req_type                req_data,
   output logic                        empty,
   input  wire logic                   pop,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   cmd_type wr_cmd, rd_cmd;
   logic    q_wr_en, q_rd_en, q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code <= 8'd16;
         cfg_ff.end_code   <= 8'd3;
         cfg_ff.alt_code   <= 8'd4;
         cfg_ff.big_mode   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_CODE: cfg_ff.start_code <= csr_wdata[7:0];
            CSR_END_CODE:   cfg_ff.end_code   <= csr_wdata[7:0];
            CSR_ALT_CODE:   cfg_ff.alt_code   <= csr_wdata[7:0];
            CSR_BIG_MODE:   cfg_ff.big_mode   <= csr_wdata[0];
         endcase
      end
   end

   dleft_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .req_data (req_data),
      .q_full   (full),
      .q_wr_en  (q_wr_en),
      .q_cmd    (wr_cmd)
   );

   dleft_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr_en),
      .wr_cmd   (wr_cmd),
      .full     (full),
      .rd_en    (q_rd_en),
      .rd_cmd   (rd_cmd),
      .rd_valid (q_valid)
   );

   dleft_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_cmd    (rd_cmd),
      .q_valid  (q_valid),
      .q_rd_en  (q_rd_en),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/dleft_checker.sv]
// ----------------------------------------------------------------------------
// dleft_checker
// Port-level checks of the DLE frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dle_frame_transmitter_macros.svh"

module dleft_checker import dleft_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    full,
   input wire logic    empty,
   input wire logic    pop,
   input wire rsp_type rsp_data
);

   // Nothing is waiting on the result side right after reset.
   `DLEFT_ASSERT_ALWAYS(a_empty_after_reset, reset |=> empty, "not empty after reset")

   // The queue starts out with room for a transfer.
   `DLEFT_ASSERT_ALWAYS(a_room_after_reset, reset |=> !full, "full after reset")

   // A waiting result that is not popped stays on the ports unchanged.
   `DLEFT_ASSERT(a_rsp_hold, !empty && !pop |=> !empty && $stable(rsp_data), "result moved")

   // While reset is held, the result side stays empty.
   `DLEFT_ASSERT_ALWAYS(a_no_early_rsp, $past(reset) && reset |=> empty, "early result")

endmodule

bind dle_frame_transmitter dleft_checker u_checker (.*);

`default_nettype wire

[bench/dle_frame_transmitter_check.sv]
// ----------------------------------------------------------------------------
// dle_frame_transmitter_check
// Watches the item, line byte and register ports of the frame transmitter.
// It frames every accepted item itself and compares each popped line byte,
// in order, with the bytes it has framed.
// ----------------------------------------------------------------------------
module dle_frame_transmitter_check import dleft_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  req_type                req_data,
   input  logic                   empty,
   input  logic                   pop,
   input  rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     checked_count
);

   localparam logic [7:0] START_AT_RESET = 8'h10;
   localparam logic [7:0] END_AT_RESET   = 8'h03;
   localparam logic [7:0] ALT_AT_RESET   = 8'h04;

   cfg_type    codes;
   logic [7:0] sum_q;
   logic [7:0] seq_q;
   logic       dropping_q;
   rsp_type    due_bytes[$];
   rsp_type    want;
   int         errs;
   int         seen;

   task automatic queue_line_byte(input logic [7:0] b, input logic done);
      rsp_type r;
      r.line_byte  = b;
      r.frame_done = done;
      due_bytes.push_back(r);
   endtask

   // Start code doubles itself; end code goes out as start code and alternate.
   // A byte equal to both codes takes the start code form.
   task automatic queue_escaped(input logic [7:0] b);
      if (b == codes.start_code) begin
         queue_line_byte(codes.start_code, 1'b0);
         queue_line_byte(codes.start_code, 1'b0);
      end else if (b == codes.end_code) begin
         queue_line_byte(codes.start_code, 1'b0);
         queue_line_byte(codes.alt_code, 1'b0);
      end else begin
         queue_line_byte(b, 1'b0);
      end
   endtask

   task automatic fold_sum(input logic [7:0] b);
      logic [9:0] t;
      seq_q = seq_q + 8'd1;
      t = (({2'b00, sum_q} << 1) + {2'b00, b}) ^ {2'b00, seq_q};
      if (t[8]) begin
         t = t + 10'd1;
      end
      sum_q = t[7:0];
   endtask

   task automatic frame_item(input req_type it);
      if (it.first_item) begin
         sum_q      = SUM_SEED;
         seq_q      = SEQ_SEED;
         dropping_q = it.pkt_kind == codes.start_code || it.pkt_kind == codes.end_code ||
                      it.pkt_addr == codes.start_code || it.pkt_addr == codes.end_code;
         if (!dropping_q) begin
            if (codes.big_mode) begin
               queue_line_byte(codes.end_code, 1'b0);
            end
            queue_line_byte(codes.start_code, 1'b0);
            queue_line_byte(it.pkt_kind, 1'b0);
            queue_line_byte(it.pkt_addr, 1'b0);
            fold_sum(it.pkt_kind);
            fold_sum(it.pkt_addr);
         end
      end
      // Items without a first flag carry on the running checksum unless the
      // current packet was refused.
      if (!dropping_q) begin
         if (it.has_payload) begin
            fold_sum(it.payload);
            queue_escaped(it.payload);
         end
         if (it.last_item) begin
            queue_escaped(sum_q);
            if (codes.big_mode) begin
               queue_line_byte(codes.start_code, 1'b0);
            end
            queue_line_byte(codes.end_code, 1'b1);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         codes.start_code = START_AT_RESET;
         codes.end_code   = END_AT_RESET;
         codes.alt_code   = ALT_AT_RESET;
         codes.big_mode   = 1'b0;
         sum_q            = SUM_SEED;
         seq_q            = SEQ_SEED;
         dropping_q       = 1'b0;
         due_bytes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_CODE: codes.start_code = csr_wdata[7:0];
               CSR_END_CODE:   codes.end_code   = csr_wdata[7:0];
               CSR_ALT_CODE:   codes.alt_code   = csr_wdata[7:0];
               CSR_BIG_MODE:   codes.big_mode   = csr_wdata[0];
               default: ;
            endcase
         end
         if (push && !full) begin
            frame_item(req_data);
         end
         if (pop && !empty) begin
            if (due_bytes.size() == 0) begin
               $error("line byte %02h (frame_done %0b) transferred with nothing due",
                      rsp_data.line_byte, rsp_data.frame_done);
               errs++;
            end else begin
               want = due_bytes.pop_front();
               seen++;
               if (rsp_data.line_byte !== want.line_byte) begin
                  $error("line_byte: expected %02h, got %02h",
                         want.line_byte, rsp_data.line_byte);
                  errs++;
               end
               if (rsp_data.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0b, got %0b",
                         want.frame_done, rsp_data.frame_done);
                  errs++;
               end
            end
         end
      end
      pending       <= due_bytes.size();
      fail_count    <= errs;
      checked_count <= seen;
   end

endmodule

[bench/dle_frame_transmitter_test.sv]
// ----------------------------------------------------------------------------
// dle_frame_transmitter_test
// Drives packets into the frame transmitter under several code settings.
// A directed part covers the corner cases, then random packets with noise
// run with idle gaps on both sides; a separate checker judges the output.
// ----------------------------------------------------------------------------
module dle_frame_transmitter_test;
   import dleft_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_CYCLES  = 400;
   localparam int PHASE_ITEMS   = 30;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic                   full;
   req_type                req_data  = '0;
   logic                   empty;
   logic                   pop       = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   checked_count;
   int   cycles;
   int   transfers;
   int   settings_done;
   bit   stall_req;
   logic [7:0] cur_start = 8'h10;
   logic [7:0] cur_end   = 8'h03;
   logic [7:0] cur_alt   = 8'h04;

   dle_frame_transmitter u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dle_frame_transmitter_check u_check (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Run timed out with %0d line bytes still due.", pending);
         $display("tb: failure");
         $finish;
      end
   end

   // Line side: random pauses per transfer, bursts without pauses, and one
   // long stall whenever the stimulus side asks for it.
   initial begin : line_sink
      int gap;
      int burst_left;
      bit stall_seen;
      burst_left = 0;
      stall_seen = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (stall_req != stall_seen) begin
            gap        = STALL_CYCLES;
            stall_seen = stall_req;
         end else if (burst_left > 0) begin
            gap = 0;
            burst_left--;
         end else begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 9) == 0) begin
               burst_left = $urandom_range(10, 40);
            end
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   function automatic req_type item_of(input logic [7:0] kind, input logic [7:0] addr,
                                       input logic [7:0] data, input logic has,
                                       input logic first, input logic last);
      req_type r;
      r.pkt_kind    = kind;
      r.pkt_addr    = addr;
      r.payload     = data;
      r.has_payload = has;
      r.first_item  = first;
      r.last_item   = last;
      return r;
   endfunction

   function automatic logic [7:0] header_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == cur_start || b == cur_end);
      return b;
   endfunction

   // Payload bytes lean toward the codes so that escaping is exercised.
   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 7))
         0:       return cur_start;
         1:       return cur_end;
         2:       return cur_alt;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input req_type it, input bit eager);
      int gap;
      gap = eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (full);
      transfers++;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_codes(input logic [7:0] sc, input logic [7:0] ec,
                            input logic [7:0] ac, input logic bm);
      cur_start = sc;
      cur_end   = ec;
      cur_alt   = ac;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_START_CODE;
      csr_wdata <= sc;
      @(posedge clock);
      csr_index <= CSR_END_CODE;
      csr_wdata <= ec;
      @(posedge clock);
      csr_index <= CSR_ALT_CODE;
      csr_wdata <= ac;
      @(posedge clock);
      csr_index <= CSR_BIG_MODE;
      csr_wdata <= {7'd0, bm};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_done++;
   endtask

   // One packet, well formed apart from an occasional bad header or a
   // payload-less item.
   task automatic send_packet(inout int good);
      int         len;
      bit         eager;
      bit         bad;
      bit         bare;
      req_type    it;
      len   = $urandom_range(1, 6);
      eager = ($urandom_range(0, 4) == 0);
      bad   = ($urandom_range(0, 9) == 0);
      bare  = (len == 1) && ($urandom_range(0, 2) == 0);
      for (int k = 0; k < len; k++) begin
         it = item_of(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      payload_byte(),
                      !bare && ($urandom_range(0, 19) != 0), k == 0, k == len - 1);
         if (k == 0) begin
            it.pkt_kind = header_byte();
            it.pkt_addr = header_byte();
            if (bad) begin
               if ($urandom_range(0, 1) == 1) begin
                  it.pkt_kind = $urandom_range(0, 1) ? cur_start : cur_end;
               end else begin
                  it.pkt_addr = $urandom_range(0, 1) ? cur_start : cur_end;
               end
            end
         end
         send_item(it, eager);
         if (!bad) begin
            good++;
         end
      end
   endtask

   initial begin : stimulus
      int good;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset codes: start 10, end 03, alternate 04, no big mode.
      // A stray last item straight after reset gets no header.
      send_item(item_of(8'h10, 8'h03, 8'h5A, 1'b1, 1'b0, 1'b1), 1'b0);
      send_item(item_of(8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1), 1'b0);
      send_item(item_of(8'hFF, 8'h00, 8'h10, 1'b1, 1'b1, 1'b0), 1'b0);
      send_item(item_of(8'h00, 8'h00, 8'h03, 1'b1, 1'b0, 1'b0), 1'b1);
      send_item(item_of(8'h00, 8'h00, 8'h04, 1'b1, 1'b0, 1'b0), 1'b1);
      send_item(item_of(8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0), 1'b0);
      send_item(item_of(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1), 1'b0);
      // Refused headers: nothing comes out, not even on the last item.
      send_item(item_of(8'h10, 8'h55, 8'h12, 1'b1, 1'b1, 1'b0), 1'b0);
      send_item(item_of(8'h00, 8'h00, 8'h34, 1'b1, 1'b0, 1'b1), 1'b0);
      send_item(item_of(8'h55, 8'h03, 8'h00, 1'b1, 1'b1, 1'b1), 1'b0);
      // Good packet, then items without a first flag continue its checksum.
      send_item(item_of(8'h21, 8'h22, 8'hAB, 1'b1, 1'b1, 1'b1), 1'b0);
      send_item(item_of(8'h00, 8'h00, 8'h10, 1'b1, 1'b0, 1'b0), 1'b0);
      send_item(item_of(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1), 1'b0);
      wait_drained();

      // Start and end codes equal, big mode on.
      set_codes(8'h7E, 8'h7E, 8'h7D, 1'b1);
      send_item(item_of(8'h01, 8'h02, 8'h7E, 1'b1, 1'b1, 1'b0), 1'b0);
      send_item(item_of(8'h00, 8'h00, 8'h7D, 1'b1, 1'b0, 1'b1), 1'b0);
      send_item(item_of(8'h7E, 8'h00, 8'h11, 1'b1, 1'b1, 1'b1), 1'b0);
      wait_drained();

      set_codes(8'h00, 8'hFF, 8'hFF, 1'b1);
      send_item(item_of(8'h01, 8'hFE, 8'h00, 1'b1, 1'b1, 1'b0), 1'b0);
      send_item(item_of(8'h80, 8'h7F, 8'hFF, 1'b1, 1'b0, 1'b1), 1'b0);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       set_codes(8'h10, 8'h03, 8'h04, 1'b0);
            1:       set_codes(8'h00, 8'hFF, 8'h80, 1'b1);
            2:       set_codes(8'hFF, 8'h00, 8'h00, 1'b0);
            3:       set_codes(8'h55, 8'h55, 8'hAA, 1'b1);
            default: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         endcase
         good = 0;
         n    = 0;
         while (good < PHASE_ITEMS) begin
            // Long line stall while items keep coming, so the input backs up.
            if (p == 1 && n == 2) begin
               stall_req <= ~stall_req;
            end
            if (p == 2 && n == 2) begin
               wait_drained();
            end
            if ($urandom_range(0, 9) == 0) begin
               send_item(item_of(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                         1'b0);
            end else begin
               send_packet(good);
            end
            n++;
         end
         wait_drained();
      end

      $display("Run sent %0d items under %0d code settings, with idle gaps on both sides,",
               transfers, settings_done);
      $display("a long line stall and drained pauses; %0d line bytes compared, %0d errors.",
               checked_count, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dleft_pkg.sv
hw/rtl/dleft_queue.sv
hw/rtl/dleft_front.sv
hw/rtl/dleft_back.sv
hw/rtl/dle_frame_transmitter.sv
hw/rtl/dleft_checker.sv
bench/dle_frame_transmitter_check.sv
bench/dle_frame_transmitter_test.sv
